/* sv/bctd_pkg.sv */
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared widths, defaults and the command and status types that join the
// controller and the datapath of the code tree decoder.
// ----------------------------------------------------------------------------
package bctd_pkg;

  // Fixed field widths of the item, result and register ports.
  localparam int CODE_W = 32;
  localparam int CODE_IW = $clog2(CODE_W);
  localparam int LEN_W = 6;
  localparam int SYM_W = 9;
  localparam int CFG_W = 10;

  // Defaults for the top-level parameters.
  localparam int NODE_COUNT_DEF = 1024;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_BITS_DEF = 9;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DEC_NEXT,
    OP_DEC_LEAF,
    OP_INS_STEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic item_decode;
    logic root_busy;
    logic root_zero;
    logic nxt_zero;
    logic leaf;
    logic rem_zero;
    logic link_zero;
    logic full;
    logic out_free;
  } sts_t;

endpackage

/* sv/bctd_ctrl.sv */
// ----------------------------------------------------------------------------
// bctd_ctrl
// Sequencer of the code tree decoder: steps the datapath through decode
// steps, insert walks and result hand-off.
// ----------------------------------------------------------------------------
module bctd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bctd_pkg::sts_t   sts,
  output bctd_pkg::cmd_t   cmd
);
  import bctd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC_NEXT,
    S_DEC_LEAF,
    S_INS_STEP,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE) || sts.root_busy;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.op = OP_LOAD;
          if (sts.item_decode) begin
            state_next = S_DEC_NEXT;
          end else if (!sts.root_zero) begin
            state_next = S_INS_STEP;
          end
        end
      end
      S_DEC_NEXT: begin
        cmd.op = OP_DEC_NEXT;
        state_next = sts.nxt_zero ? S_EMIT : S_DEC_LEAF;
      end
      S_DEC_LEAF: begin
        cmd.op = OP_DEC_LEAF;
        state_next = sts.leaf ? S_EMIT : S_IDLE;
      end
      S_INS_STEP: begin
        cmd.op = OP_INS_STEP;
        if (sts.rem_zero) begin
          state_next = S_IDLE;
        end else if (sts.link_zero && sts.full) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/bctd_dp.sv */
// ----------------------------------------------------------------------------
// bctd_dp
// Datapath of the code tree decoder: node memory, walk registers, root
// register with its reduction, and the output register.
// ----------------------------------------------------------------------------
module bctd_dp #(
  parameter int NODE_COUNT = bctd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = bctd_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_BITS = bctd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bctd_pkg::cmd_t               cmd,
  output bctd_pkg::sts_t               sts,
  input  logic                         cfg_wr_en,
  input  logic [bctd_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         action,
  input  logic [bctd_pkg::CODE_W-1:0]  code_bits,
  input  logic [bctd_pkg::LEN_W-1:0]   code_length,
  input  logic [bctd_pkg::SYM_W-1:0]   symbol_value,
  input  logic                         coded_bit,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [bctd_pkg::SYM_W-1:0]   symbol,
  output logic                         bad_code,
  output logic                         store_full
);
  import bctd_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int SW = SYMBOL_BITS;
  localparam int EW = 2 * NW + SW;
  localparam int FW = NW + 1;
  localparam int RW = CFG_W + 17;

  // Node memory: each entry is {child0, child1, symbol}.
  logic [EW-1:0] mem [NODE_COUNT];
  logic [EW-1:0] rd_q;
  logic          rd_zero;
  logic          node1_valid;

  logic [NW-1:0] raddr;
  logic          we;
  logic [NW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic [CFG_W-1:0]   root;
  logic               root_busy;
  logic [NW-1:0]      current;
  logic               dbit;
  logic [NW-1:0]      nxt_q;
  logic [NW-1:0]      cur;
  logic [LEN_W-1:0]   rem;
  logic [CODE_W-1:0]  code;
  logic [SW-1:0]      sym;
  logic               node_new;
  logic [FW-1:0]      next_free;
  logic [SW-1:0]      res_sym;
  logic               res_bad;
  logic               res_full;

  logic [CFG_W+NW-1:0]  root_ext;
  logic [NW-1:0]        root_idx;
  logic                 root_big;
  logic [EW-1:0]        rd_eff;
  logic [EW-1:0]        nd;
  logic [NW-1:0]        dec_k0;
  logic [NW-1:0]        dec_k1;
  logic [SW-1:0]        dec_s;
  logic [NW-1:0]        dec_nxt;
  logic [NW-1:0]        ins_k0;
  logic [NW-1:0]        ins_k1;
  logic [SW-1:0]        ins_s;
  logic [LEN_W-1:0]     rem_m1;
  logic                 ins_bit;
  logic [NW-1:0]        ins_link;
  logic                 full;
  logic [EW-1:0]        alloc_entry;
  logic [LEN_W-1:0]     len_sat;
  logic [SYM_W+SW-1:0]  sym_in_ext;
  logic [SYM_W+SW-1:0]  sym_out_ext;
  logic                 out_free;

  assign root_ext = {{NW{1'b0}}, root};
  assign root_idx = root_ext[NW-1:0];
  assign root_big = {{17{1'b0}}, root} >= RW'(NODE_COUNT);

  // Node 0 always reads as empty; node 1 reads as empty until first written.
  assign rd_eff = rd_zero ? '0 : rd_q;
  // A freshly allocated node is known to be clear and is not read back.
  assign nd = node_new ? '0 : rd_eff;

  assign dec_k0 = rd_eff[EW-1 -: NW];
  assign dec_k1 = rd_eff[EW-NW-1 -: NW];
  assign dec_s = rd_eff[SW-1:0];
  assign dec_nxt = dbit ? dec_k1 : dec_k0;

  assign ins_k0 = nd[EW-1 -: NW];
  assign ins_k1 = nd[EW-NW-1 -: NW];
  assign ins_s = nd[SW-1:0];
  assign rem_m1 = rem - LEN_W'(1);
  assign ins_bit = (rem_m1 < LEN_W'(CODE_W)) ? code[rem_m1[CODE_IW-1:0]] : 1'b0;
  assign ins_link = ins_bit ? ins_k1 : ins_k0;
  assign full = next_free >= FW'(NODE_COUNT);
  assign alloc_entry = ins_bit ? {ins_k0, next_free[NW-1:0], ins_s}
                               : {next_free[NW-1:0], ins_k1, ins_s};

  assign len_sat = ({1'b0, code_length} > (LEN_W + 1)'(MAX_CODE_LEN))
                   ? LEN_W'(MAX_CODE_LEN) : code_length;
  assign sym_in_ext = {{SW{1'b0}}, symbol_value};
  assign sym_out_ext = {{SYM_W{1'b0}}, res_sym};

  assign out_free = !out_valid || !out_stall;

  assign sts.item_decode = action;
  assign sts.root_busy = root_busy;
  assign sts.root_zero = (root_idx == '0);
  assign sts.nxt_zero = (dec_nxt == '0);
  assign sts.leaf = (dec_k0 == dec_k1);
  assign sts.rem_zero = (rem == '0);
  assign sts.link_zero = (ins_link == '0);
  assign sts.full = full;
  assign sts.out_free = out_free;

  // Memory port selection for each command.
  always_comb begin
    raddr = current;
    we = 1'b0;
    waddr = cur;
    wdata = alloc_entry;
    case (cmd.op)
      OP_LOAD: begin
        raddr = action ? current : root_idx;
      end
      OP_DEC_NEXT: begin
        raddr = dec_nxt;
      end
      OP_INS_STEP: begin
        if (rem == '0) begin
          we = 1'b1;
          wdata = {ins_k0, ins_k1, sym};
        end else if (ins_link != '0) begin
          raddr = ins_link;
        end else if (full) begin
          // The node allocated last is still unwritten; clear it before stopping.
          we = node_new;
          wdata = '0;
        end else begin
          we = 1'b1;
        end
      end
      default: begin
        raddr = current;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node1_valid <= 1'b0;
      rd_zero <= 1'b1;
    end else begin
      if (we && waddr == NW'(1)) begin
        node1_valid <= 1'b1;
      end
      rd_zero <= (raddr == '0) || (raddr == NW'(1) && !node1_valid);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= CFG_W'(1);
      root_busy <= 1'b0;
      current <= NW'(1);
      next_free <= FW'(2);
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_DEC_NEXT: begin
          if (dec_nxt == '0) begin
            current <= root_idx;
          end
        end
        OP_DEC_LEAF: begin
          current <= (dec_k0 == dec_k1) ? root_idx : nxt_q;
        end
        OP_INS_STEP: begin
          if (rem != '0 && ins_link == '0 && !full) begin
            next_free <= next_free + FW'(1);
          end
        end
        default: begin
        end
      endcase

      if (cmd.op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      // The root is reduced into the store range by repeated subtraction.
      if (cfg_wr_en) begin
        root <= cfg_wr_data;
        root_busy <= 1'b1;
      end else if (root_busy) begin
        if (root_big) begin
          root <= root - CFG_W'(NODE_COUNT);
        end else begin
          root_busy <= 1'b0;
          current <= root_idx;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dbit <= coded_bit;
        code <= code_bits;
        rem <= len_sat;
        sym <= sym_in_ext[SW-1:0];
        cur <= root_idx;
        node_new <= 1'b0;
      end
      OP_DEC_NEXT: begin
        nxt_q <= dec_nxt;
        res_sym <= '0;
        res_bad <= 1'b1;
        res_full <= 1'b0;
      end
      OP_DEC_LEAF: begin
        res_sym <= dec_s;
        res_bad <= 1'b0;
        res_full <= 1'b0;
      end
      OP_INS_STEP: begin
        if (rem != '0) begin
          if (ins_link != '0) begin
            cur <= ins_link;
            rem <= rem_m1;
            node_new <= 1'b0;
          end else if (full) begin
            res_sym <= '0;
            res_bad <= 1'b0;
            res_full <= 1'b1;
          end else begin
            cur <= next_free[NW-1:0];
            rem <= rem_m1;
            node_new <= 1'b1;
          end
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          symbol <= sym_out_ext[SYM_W-1:0];
          bad_code <= res_bad;
          store_full <= res_full;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/binary_code_trie_decoder.sv */
// Bit-serial decoder over a binary prefix-code tree held in a node memory
// with one read port, one write port and registered read data. Every tree
// step is one dependent memory read. A decode bit passes through DEC_NEXT and
// DEC_LEAF when it stays inside the tree, through DEC_NEXT and EMIT when it
// ends on a bad code, and through all three when it ends on a leaf. An insert
// of a code (length saturated to MAX_CODE_LEN) stops early with a store_full
// result on a full store; an insert while the root is node 0 leaves the tree
// unchanged. A write of root_node stalls the input while the root is reduced
// into the store range. A finished result waits in the output register and
// does not hold up the next input transfer, but a second result waits in the
// controller until the first one has been transferred.
// ----------------------------------------------------------------------------
// binary_code_trie_decoder
// Top level: code insertion and bit-serial decoding over a node store.
// ----------------------------------------------------------------------------
module binary_code_trie_decoder #(
  parameter int NODE_COUNT = bctd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = bctd_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_BITS = bctd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bctd_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [bctd_pkg::CODE_W-1:0]  code_bits,
  input  logic [bctd_pkg::LEN_W-1:0]   code_length,
  input  logic [bctd_pkg::SYM_W-1:0]   symbol_value,
  input  logic                         coded_bit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bctd_pkg::SYM_W-1:0]   symbol,
  output logic                         bad_code,
  output logic                         store_full
);
  import bctd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bctd_dp #(
    .NODE_COUNT   (NODE_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_BITS  (SYMBOL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .action       (action),
    .code_bits    (code_bits),
    .code_length  (code_length),
    .symbol_value (symbol_value),
    .coded_bit    (coded_bit),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .symbol       (symbol),
    .bad_code     (bad_code),
    .store_full   (store_full)
  );

  // A result never flags both a bad code and a full store.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_code && store_full))
    else $error("bad_code and store_full set together");

  // Error results carry symbol 0.
  a_error_symbol: assert property (@(posedge clk) disable iff (rst)
    out_valid && (bad_code || store_full) |-> symbol == '0)
    else $error("error result with nonzero symbol");

  // No item is taken while a new root is being reduced.
  a_root_write_stalls: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> in_stall)
    else $error("input taken during root reduction");

endmodule
